FILE: hw/rtl/mbe_pkg.sv
// shared constants, register indexes and controller/datapath types for the escape-time block
`timescale 1ns / 1ps
package mbe_pkg;

  // input point format
  localparam int IN_W           = 30;
  localparam int FRAC_BITS_DEF  = 27;
  localparam int COUNT_BITS_DEF = 8;

  // z is held one bit wider than |z| can reach after any non-escaping update
  localparam int Z_W = 33;

  // configuration registers
  localparam int LIMIT_W    = 8;
  localparam int RADIUS_W   = 31;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 8'd100;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd838860800;

  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_RADIUS = 4'd1;

  // result format
  localparam int COLOR_W   = 8;
  localparam int CNT_EXT_W = 16;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic limit_hit;
    logic escaped;
  } dp_stat_t;

endpackage

FILE: hw/rtl/mbe_if.sv
// valid/ready channel interfaces for points, results and register writes
`timescale 1ns / 1ps
interface mbe_in_if import mbe_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] c_real;
  logic signed [IN_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_out_if import mbe_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] iteration_count;
  logic                  inside_set;
  logic [COLOR_W-1:0]    red;
  logic [COLOR_W-1:0]    green;
  logic [COLOR_W-1:0]    blue;

  modport source (output valid, output iteration_count, output inside_set,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input iteration_count, input inside_set,
                  input red, input green, input blue, output ready);
endinterface

interface mbe_cfg_if import mbe_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mbe_ctrl.sv
// sequencing state machine: accept, multiply/update loop, result hand-off
`timescale 1ns / 1ps
module mbe_ctrl import mbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd_o         = '0;
    out_valid_nxt = out_valid_r & ~out_ready_i;
    case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (stat_i.limit_hit || stat_i.escaped) begin
          state_nxt = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_DONE: begin
        // wait for the result slot to be free or drained this cycle
        if (!out_valid_r || out_ready_i) begin
          cmd_o.emit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready_o  = (state_r == S_IDLE);
  assign out_valid_o = out_valid_r;

  a_load_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> state_r == S_MUL)
    else $error("point load not followed by a multiply cycle");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result valid raised outside the done state");

endmodule

FILE: hw/rtl/mbe_datapath.sv
// z registers, three parallel multipliers, escape compare, counter and result registers
`timescale 1ns / 1ps
module mbe_datapath import mbe_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic signed [IN_W-1:0] c_real_i,
  input  logic signed [IN_W-1:0] c_imag_i,
  input  logic [LIMIT_W-1:0]     limit_i,
  input  logic [RADIUS_W-1:0]    radius_i,
  output logic [COUNT_BITS-1:0]  count_o,
  output logic                   inside_o,
  output logic [COLOR_W-1:0]     red_o,
  output logic [COLOR_W-1:0]     green_o,
  output logic [COLOR_W-1:0]     blue_o
);

  localparam int PROD_W = 2 * Z_W;
  localparam int SQ_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W  = SQ_W + 1;
  localparam int CMP_W  = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;

  logic signed [IN_W-1:0]   cr_r, ci_r;
  logic signed [Z_W-1:0]    zr_r, zi_r, zr_nxt, zi_nxt;
  logic [SQ_W-1:0]          sr_r, si_r, sr_nxt, si_nxt;
  logic signed [SQ_W-1:0]   cross_r, cross_nxt;
  logic [COUNT_BITS-1:0]    count_r, limit_cnt;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri;
  logic signed [PROD_W-1:0] q_rr, q_ii, q_ri;
  logic [CMP_W-1:0]         mag_sum;
  logic [CNT_EXT_W-1:0]     cnt_ext;

  logic [COUNT_BITS-1:0]    count_out_r;
  logic                     inside_r;
  logic [COLOR_W-1:0]       red_r, green_r, blue_r;

  // full products, then floor shift back to the point format
  assign p_rr = zr_r * zr_r;
  assign p_ii = zi_r * zi_r;
  assign p_ri = zr_r * zi_r;
  assign q_rr = p_rr >>> FRAC_BITS;
  assign q_ii = p_ii >>> FRAC_BITS;
  assign q_ri = p_ri >>> FRAC_BITS;
  assign sr_nxt    = q_rr[SQ_W-1:0];
  assign si_nxt    = q_ii[SQ_W-1:0];
  assign cross_nxt = q_ri[SQ_W-1:0];

  // update only runs when not escaped, so the true result fits in Z_W
  assign zr_nxt = Z_W'(sr_r) - Z_W'(si_r) + Z_W'(cr_r);
  assign zi_nxt = (Z_W'(cross_r) <<< 1) + Z_W'(ci_r);

  assign mag_sum   = CMP_W'(sr_r) + CMP_W'(si_r);
  assign limit_cnt = COUNT_BITS'(limit_i);

  assign stat_o.escaped   = mag_sum > CMP_W'(radius_i);
  assign stat_o.limit_hit = (count_r == limit_cnt);

  assign cnt_ext = CNT_EXT_W'(count_r);

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cr_r    <= c_real_i;
      ci_r    <= c_imag_i;
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end
    if (cmd_i.mul) begin
      sr_r    <= sr_nxt;
      si_r    <= si_nxt;
      cross_r <= cross_nxt;
    end
    if (cmd_i.step) begin
      zr_r    <= zr_nxt;
      zi_r    <= zi_nxt;
      count_r <= count_r + 1'b1;
    end
    if (cmd_i.emit) begin
      count_out_r <= count_r;
      inside_r    <= stat_o.limit_hit;
      if (stat_o.limit_hit) begin
        red_r   <= '0;
        green_r <= '0;
        blue_r  <= '0;
      end else begin
        red_r   <= {cnt_ext[2:0], 5'b0};
        green_r <= {cnt_ext[3:0], 4'b0};
        blue_r  <= {cnt_ext[4:0], 3'b0};
      end
    end
  end

  assign count_o  = count_out_r;
  assign inside_o = inside_r;
  assign red_o    = red_r;
  assign green_o  = green_r;
  assign blue_o   = blue_r;

  a_step_only_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.step |-> !stat_o.limit_hit && !stat_o.escaped)
    else $error("z updated after escape or limit");

  a_inside_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |=> inside_r == (count_out_r == $past(limit_cnt)))
    else $error("inside flag disagrees with emitted count");

endmodule

FILE: hw/rtl/mandelbrot_escape_time_top.sv
// top level of the mandelbrot escape-time block: channels, config registers, ctrl and datapath
`timescale 1ns / 1ps
// takes one point c per input beat and returns one result beat with the
// escape count, an inside flag and three color bytes derived from the count.
// the point runs z = z*z + c from z = 0, testing |z|^2 against the squared
// escape radius before each update. each update has two steps: first the
// three parallel multipliers (zr*zr, zi*zi, zr*zi) load their registers,
// then the escape compare and the z update use those registers. one point
// is worked at a time; the input side is ready again as soon as the result
// sits in the output register, even if that result has not yet been taken.
// the iteration limit resets to 100. register writes (index 0: iteration
// limit, index 1: squared radius) are always ready and must only be made
// while no point is in flight.
module mandelbrot_escape_time_top import mbe_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mbe_in_if.sink        in_chan,
  mbe_out_if.source     out_chan,
  mbe_cfg_if.sink       cfg_chan
);

  logic [LIMIT_W-1:0]  limit_r;
  logic [RADIUS_W-1:0] radius_r;
  dp_cmd_t             cmd;
  dp_stat_t            stat;

  // register writes, bits above each register's width dropped
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      radius_r <= RADIUS_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        REG_ITER_LIMIT: limit_r  <= cfg_chan.data[LIMIT_W-1:0];
        REG_ESC_RADIUS: radius_r <= cfg_chan.data[RADIUS_W-1:0];
        default: ; // unknown index, beat dropped
      endcase
    end
  end

  // sequencing
  mbe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_chan.valid),
    .in_ready_o  (in_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and result registers
  mbe_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .c_real_i (in_chan.c_real),
    .c_imag_i (in_chan.c_imag),
    .limit_i  (limit_r),
    .radius_i (radius_r),
    .count_o  (out_chan.iteration_count),
    .inside_o (out_chan.inside_set),
    .red_o    (out_chan.red),
    .green_o  (out_chan.green),
    .blue_o   (out_chan.blue)
  );

endmodule

FILE: bench/tb_mandelbrot_escape_time_top.sv
// self-checking bench for the mandelbrot escape-time block: bit-true escape predictor and scoreboard
`timescale 1ns / 1ps
module tb_mandelbrot_escape_time_top;
  import mbe_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CNT_W = COUNT_BITS_DEF;

  // register indexes the block does not decode, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  // extreme point coordinates
  localparam logic signed [IN_W-1:0] C_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] C_MIN = {1'b1, {(IN_W-1){1'b0}}};

  localparam int RAND_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 210;

  typedef struct {
    logic signed [IN_W-1:0] re;
    logic signed [IN_W-1:0] im;
  } point_t;

  typedef struct {
    logic [CNT_W-1:0]   count;
    logic               in_set;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } escape_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mbe_in_if                               in_ch ();
  mbe_out_if #(.COUNT_BITS(CNT_W))        out_ch ();
  mbe_cfg_if                              cfg_ch ();

  mandelbrot_escape_time_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench copy of the two registers, tracks every accepted register write
  logic [LIMIT_W-1:0]  limit_cfg;
  logic [RADIUS_W-1:0] radius_cfg;

  point_t         point_q[$];     // points waiting to be offered
  escape_result_t escape_q[$];    // predicted results, oldest first
  int             err_count = 0;
  int             pts_accepted = 0;
  logic           hold_off;       // long receiver hold-off, driven by its own process
  int             tx_gap, tx_burst, rx_wait, rx_burst;

  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  // fixed-point product, exact then floored by FRAC bits
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [127:0] p;
    p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
    p = p >>> FRAC;
    return p[63:0];
  endfunction

  // escape-time iteration with the current register copy
  function automatic escape_result_t predict_escape(input logic signed [IN_W-1:0] cr,
                                                    input logic signed [IN_W-1:0] ci);
    logic signed [63:0] zr, zi, sr, si, xprod, r2;
    int n;
    escape_result_t res;
    zr = 64'sd0;
    zi = 64'sd0;
    r2 = {33'd0, radius_cfg};
    n = 0;
    while (n < int'(limit_cfg)) begin
      sr = fx_mul(zr, zr);
      si = fx_mul(zi, zi);
      // strict compare before the update
      if (sr + si > r2) break;
      xprod = fx_mul(zr, zi);
      zr = sr - si + cr;
      zi = 2 * xprod + ci;
      n++;
    end
    res.count  = n[CNT_W-1:0];
    res.in_set = (n == int'(limit_cfg));
    res.red    = res.in_set ? '0 : {n[2:0], 5'b0};
    res.green  = res.in_set ? '0 : {n[3:0], 4'b0};
    res.blue   = res.in_set ? '0 : {n[4:0], 3'b0};
    return res;
  endfunction

  function automatic logic signed [IN_W-1:0] fixp(input real v);
    return IN_W'($rtoi(v * 134217728.0));
  endfunction

  // idle length: mostly none or short, a few long, plus bursts with no idling
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // most points sit around the set so the count runs long, some span
  // the whole 30-bit field so every bit toggles, the rest sit at the real extremes
  function automatic point_t rand_point();
    point_t p;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      p.re = IN_W'($urandom);
      p.im = IN_W'($urandom);
    end else if (sel < 9) begin
      p.re = IN_W'(int'($urandom_range(0, 335544320)) - 268435456);
      p.im = IN_W'(int'($urandom_range(0, 335544320)) - 167772160);
    end else begin
      p.re = ($urandom_range(0, 1) == 1) ? C_MAX : C_MIN;
      p.im = IN_W'(int'($urandom_range(0, 64)) - 32);
    end
    return p;
  endfunction

  task automatic add_point(input logic signed [IN_W-1:0] re,
                           input logic signed [IN_W-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    point_q.push_back(p);
  endtask

  // one register write beat, the bench copy follows the decode of the block
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ITER_LIMIT: limit_cfg  = val[LIMIT_W-1:0];
      REG_ESC_RADIUS: radius_cfg = val[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding; then a
  // short settle before any register write
  task automatic wait_idle();
    do @(posedge clk); while (point_q.size() != 0 || escape_q.size() != 0 || in_ch.valid);
    repeat (8) @(posedge clk);
  endtask

  // known levels on every block input from time zero
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.c_real    = '0;
    in_ch.c_imag    = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    hold_off        = 1'b0;
    limit_cfg       = LIMIT_RST;
    radius_cfg      = RADIUS_RST;
    tx_gap          = 0;
    tx_burst        = 0;
    rx_wait         = 0;
    rx_burst        = 0;
  end

  // point driver: holds a beat until taken, then idles a random gap before the next
  always @(posedge clk) begin : point_driver
    point_t nxt;
    logic   fire;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        // prediction from the payload as accepted at this edge
        escape_q.push_back(predict_escape(in_ch.c_real, in_ch.c_imag));
        pts_accepted++;
        tx_gap = pick_gap(tx_burst);
      end
      if (fire || !in_ch.valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (point_q.size() != 0) begin
          nxt = point_q.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.c_real <= nxt.re;
          in_ch.c_imag <= nxt.im;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each beat against the oldest prediction, ready
  // drops at random and for the whole hold-off stretch
  always @(posedge clk) begin : result_monitor
    escape_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (escape_q.size() == 0) begin
          flag_error("result beat with no prediction waiting");
        end else begin
          want = escape_q.pop_front();
          if (out_ch.iteration_count !== want.count)
            flag_error($sformatf("iteration_count got %0d want %0d",
                                 out_ch.iteration_count, want.count));
          if (out_ch.inside_set !== want.in_set)
            flag_error($sformatf("inside_set got %0b want %0b", out_ch.inside_set, want.in_set));
          if (out_ch.red !== want.red)
            flag_error($sformatf("red got %0d want %0d", out_ch.red, want.red));
          if (out_ch.green !== want.green)
            flag_error($sformatf("green got %0d want %0d", out_ch.green, want.green));
          if (out_ch.blue !== want.blue)
            flag_error($sformatf("blue got %0d want %0d", out_ch.blue, want.blue));
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) rx_wait = pick_gap(rx_burst);
      end
    end
  end

  // one long receiver hold-off mid run: one result parks in the output
  // register, the next point fills the core and the input side stalls
  initial begin : long_hold_off
    wait (pts_accepted >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (2500) @(posedge clk);
    hold_off <= 1'b0;
  end

  // stimulus sequence
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] lim_w, rad_w;
    int ph, k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values, field extremes and well known points
    add_point(0, 0);                       // origin, never moves
    add_point(C_MIN, C_MIN);               // far corner, escapes after one update
    add_point(C_MAX, C_MAX);
    add_point(C_MAX, 0);
    add_point(C_MIN, 0);
    add_point(0, C_MAX);
    add_point(0, C_MIN);
    add_point(fixp(-2.0), 0);              // tip of the set, z bounces at 2
    add_point(fixp(0.25), 0);              // cusp on the real axis
    add_point(fixp(-1.0), 0);              // z alternates between 0 and -1
    add_point(0, fixp(1.0));               // i, preperiodic
    add_point(fixp(-0.75), fixp(0.1));     // neck, slow escape
    add_point(fixp(0.5), fixp(0.5));
    add_point(-1, 1);                      // one lsb either side
    add_point(30'sh15555555, 30'sh2AAAAAAA);
    wait_idle();

    // zero limit: no update, every point counts as inside
    write_reg(REG_ITER_LIMIT, 32'd0);
    add_point(0, 0);
    add_point(C_MIN, C_MAX);
    add_point(30'sh2AAAAAAA, 30'sh15555555);
    wait_idle();

    // zero radius with the longest limit: only c = 0 survives past the first update
    write_reg(REG_ITER_LIMIT, 32'd255);
    write_reg(REG_ESC_RADIUS, 32'd0);
    add_point(0, 0);
    add_point(fixp(0.01), 0);
    add_point(C_MAX, C_MIN);
    wait_idle();

    // junk above the register widths, writes to undecoded indexes, widest radius
    write_reg(REG_ITER_LIMIT, 32'hFFFF_FF40);
    write_reg(REG_UNUSED_LO, 32'h0000_0001);
    write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
    write_reg(REG_ESC_RADIUS, 32'hFFFF_FFFF);
    add_point(fixp(-2.0), 0);
    add_point(fixp(0.3), fixp(0.5));
    add_point(fixp(-0.1), fixp(0.9));
    wait_idle();

    // random phases, one register setting each
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin lim_w = 32'd100; rad_w = 32'd838860800; end
        1: begin lim_w = 32'd255; rad_w = 32'h7FFF_FFFF; end
        2: begin lim_w = 32'd1;   rad_w = 32'd0; end
        3: begin lim_w = $urandom_range(1, 40); rad_w = $urandom_range(0, 32'h7FFF_FFFF); end
        4: begin lim_w = 32'd0;   rad_w = $urandom; end
        5: begin
          lim_w = $urandom_range(50, 255);
          rad_w = $urandom_range(32'h2000_0000, 32'h7FFF_FFFF);
        end
        6: begin lim_w = 32'd255; rad_w = 32'd838860800; end
        default: begin lim_w = 32'hA5A5_A540; rad_w = 32'h9000_0000; end
      endcase
      write_reg(REG_ITER_LIMIT, lim_w);
      write_reg(REG_ESC_RADIUS, rad_w);
      for (k = 0; k < ITEMS_PER_PHASE; k++) point_q.push_back(rand_point());
      wait_idle();
    end

    // drain: room for one more worst case point to show up unexpected
    repeat (600) @(posedge clk);
    if (escape_q.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", escape_q.size()));
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
